[hw/rtl/ols_pkg.sv]
// ----------------------------------------------------------------------------
// ols_pkg
// Shared types and codes for the ordered list store and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ols_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ReqW  = 2;
  localparam int unsigned PosW  = 8;

  // Request codes on req_type_i
  localparam logic [ReqW-1:0] ReqPushFront = 2'd0;
  localparam logic [ReqW-1:0] ReqAppend    = 2'd1;
  localparam logic [ReqW-1:0] ReqDelete    = 2'd2;

  // Operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OpHold,
    OpPushFront,
    OpAppend,
    OpDelete,
    OpRotate
  } cell_op_e;

endpackage

`default_nettype wire

[hw/rtl/ols_cell.sv]
// ----------------------------------------------------------------------------
// ols_cell
// One storage slot of the list chain. Decides from the broadcast operation
// and its own position whether to hold, take a neighbor's value, the head's value or the new one.
// ----------------------------------------------------------------------------
`default_nettype none

module ols_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned CntW  = 5
) (
  input  wire                            clk_i,
  input  wire ols_pkg::cell_op_e         op_i,
  input  wire [ols_pkg::PosW-1:0]        pos_i,
  input  wire [CntW-1:0]                 count_i,
  input  wire [ols_pkg::DataW-1:0]       value_i,
  input  wire [ols_pkg::DataW-1:0]       left_i,
  input  wire [ols_pkg::DataW-1:0]       right_i,
  input  wire [ols_pkg::DataW-1:0]       head_i,
  output logic [ols_pkg::DataW-1:0]      data_o
);

  localparam logic [CntW-1:0]          MyIdx  = CntW'(Index);
  localparam logic [CntW-1:0]          MyNext = CntW'(Index + 1);
  localparam logic [ols_pkg::PosW-1:0] MyPos  = ols_pkg::PosW'(Index);

  logic [ols_pkg::DataW-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    unique case (op_i)
      ols_pkg::OpPushFront: begin
        data_d = (Index == 0) ? value_i : left_i;
      end
      ols_pkg::OpAppend: begin
        if (count_i == MyIdx) data_d = value_i;
      end
      ols_pkg::OpDelete: begin
        if ((MyPos >= pos_i) && (MyNext < count_i)) data_d = right_i;
      end
      ols_pkg::OpRotate: begin
        // rotate the occupied part left by one; the tail gets the old head
        if (MyNext < count_i) begin
          data_d = right_i;
        end else if (MyNext == count_i) begin
          data_d = head_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

[hw/rtl/ordered_list_store_unit.sv]
// ----------------------------------------------------------------------------
// ordered_list_store_unit
// Bounded ordered list of signed 32-bit values with push-front, append and
// delete-at-index; the whole list is streamed out after each request.
// ----------------------------------------------------------------------------
// The list lives in a chain of CAPACITY cells; the update happens in the
// cycle the request transaction is accepted, then the list is streamed out
// front to back by rotating the occupied cells one step per output
// transaction, which leaves them in their original order at the end. The
// next request is taken once the last result has been accepted. No clearing
// pass is needed after reset.
`default_nettype none

module ordered_list_store_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire [ols_pkg::ReqW-1:0]           req_type_i,
  input  wire signed [ols_pkg::DataW-1:0]   item_value_i,
  input  wire [ols_pkg::PosW-1:0]           position_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic signed [ols_pkg::DataW-1:0]  element_o,
  output logic                              last_of_run_o,
  output logic                              list_empty_o,
  output logic                              insert_dropped_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  localparam logic StIdle = 1'b0;
  localparam logic StEmit = 1'b1;

  logic                 state_d, state_q;
  logic [CntW-1:0]      count_d, count_q;
  logic [CntW-1:0]      remain_d, remain_q;
  logic                 dropped_d, dropped_q;
  ols_pkg::cell_op_e    op;
  logic                 in_fire, out_fire;
  logic                 full;

  logic [ols_pkg::DataW-1:0] cell_val [CAPACITY];

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;
  assign full     = (count_q == CapCnt);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    remain_d  = remain_q;
    dropped_d = dropped_q;
    op        = ols_pkg::OpHold;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d   = StEmit;
          dropped_d = 1'b0;
          priority if (req_type_i == ols_pkg::ReqPushFront ||
                       req_type_i == ols_pkg::ReqAppend) begin
            if (full) begin
              dropped_d = 1'b1;
            end else begin
              op      = (req_type_i == ols_pkg::ReqPushFront) ?
                        ols_pkg::OpPushFront : ols_pkg::OpAppend;
              count_d = count_q + 1'b1;
            end
          end else if (req_type_i == ols_pkg::ReqDelete) begin
            if (position_i < ols_pkg::PosW'(count_q)) begin
              op      = ols_pkg::OpDelete;
              count_d = count_q - 1'b1;
            end
          end else begin
            op = ols_pkg::OpHold;
          end
          remain_d = count_d;
        end
      end
      StEmit: begin
        if (out_fire) begin
          if (count_q != '0) op = ols_pkg::OpRotate;
          if (remain_q <= CntW'(1)) begin
            state_d = StIdle;
          end else begin
            remain_d = remain_q - 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      remain_q  <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      remain_q  <= remain_d;
      dropped_q <= dropped_d;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ols_cell #(
      .Index (g),
      .CntW  (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .pos_i   (position_i),
      .count_i (count_q),
      .value_i (item_value_i),
      .left_i  ((g == 0) ? item_value_i : cell_val[(g == 0) ? 0 : g - 1]),
      .right_i (cell_val[(g == CAPACITY - 1) ? g : g + 1]),
      .head_i  (cell_val[0]),
      .data_o  (cell_val[g])
    );
  end

  assign in_stall_o       = (state_q != StIdle);
  assign out_valid_o      = (state_q == StEmit);
  assign list_empty_o     = (count_q == '0);
  assign element_o        = list_empty_o ? '0 : cell_val[0];
  assign last_of_run_o    = (remain_q <= CntW'(1));
  assign insert_dropped_o = dropped_q;

endmodule

`default_nettype wire

[tb/ols_list_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ols_list_checker
// Watches both channels of the ordered list store, keeps its own copy of the
// list, builds the expected stream for each request and checks every result.
// ----------------------------------------------------------------------------

module ols_list_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic [ols_pkg::ReqW-1:0]            req_type_i,
  input  logic signed [ols_pkg::DataW-1:0]    item_value_i,
  input  logic [ols_pkg::PosW-1:0]            position_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [ols_pkg::DataW-1:0]    element_i,
  input  logic                                last_of_run_i,
  input  logic                                list_empty_i,
  input  logic                                insert_dropped_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);

  typedef struct packed {
    logic signed [ols_pkg::DataW-1:0] element;
    logic                             last;
    logic                             empty;
    logic                             dropped;
  } list_result_t;

  logic signed [ols_pkg::DataW-1:0] list_vals [CAPACITY];
  int                               list_len = 0;
  list_result_t                     expected_stream_q [$];
  int                               fails = 0;
  int                               waiting = 0;

  assign fail_count_o = fails;
  assign pending_o    = waiting;

  // Apply one request to the shadow list and queue the stream it produces.
  task automatic update_list_and_expect_stream(
    input logic [ols_pkg::ReqW-1:0]         kind,
    input logic signed [ols_pkg::DataW-1:0] value,
    input logic [ols_pkg::PosW-1:0]         pos
  );
    logic dropped;
    dropped = 1'b0;
    case (kind)
      ols_pkg::ReqPushFront, ols_pkg::ReqAppend: begin
        if (list_len >= CAPACITY) begin
          dropped = 1'b1;
        end else if (kind == ols_pkg::ReqPushFront) begin
          for (int i = list_len; i > 0; i--) list_vals[i] = list_vals[i-1];
          list_vals[0] = value;
          list_len++;
        end else begin
          list_vals[list_len] = value;
          list_len++;
        end
      end
      ols_pkg::ReqDelete: begin
        if (int'(pos) < list_len) begin
          for (int i = pos; i < list_len - 1; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      default: ;
    endcase

    if (list_len == 0) begin
      expected_stream_q.push_back('{element: '0, last: 1'b1, empty: 1'b1,
                                    dropped: dropped});
    end else begin
      for (int i = 0; i < list_len; i++)
        expected_stream_q.push_back('{element: list_vals[i],
                                      last: (i == list_len - 1),
                                      empty: 1'b0, dropped: dropped});
    end
  endtask

  task automatic check_stream_result();
    list_result_t want;
    if (expected_stream_q.size() == 0) begin
      $display("%0t: unexpected result: element %0d last %0b empty %0b dropped %0b",
               $time, element_i, last_of_run_i, list_empty_i, insert_dropped_i);
      fails++;
    end else begin
      want = expected_stream_q.pop_front();
      // element carries no meaning on an empty-list result
      if (!want.empty && element_i !== want.element) begin
        $display("%0t: element mismatch: expected %0d actual %0d",
                 $time, want.element, element_i);
        fails++;
      end
      if (last_of_run_i !== want.last) begin
        $display("%0t: last_of_run mismatch: expected %0b actual %0b",
                 $time, want.last, last_of_run_i);
        fails++;
      end
      if (list_empty_i !== want.empty) begin
        $display("%0t: list_empty mismatch: expected %0b actual %0b",
                 $time, want.empty, list_empty_i);
        fails++;
      end
      if (insert_dropped_i !== want.dropped) begin
        $display("%0t: insert_dropped mismatch: expected %0b actual %0b",
                 $time, want.dropped, insert_dropped_i);
        fails++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      expected_stream_q.delete();
      waiting = 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        update_list_and_expect_stream(req_type_i, item_value_i, position_i);
      if (out_valid_i && !out_stall_i)
        check_stream_result();
      waiting = expected_stream_q.size();
    end
  end

endmodule

[tb/tb_ordered_list_store_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_store_unit
// Drives push-front, append, delete and unused-code requests into the ordered list store,
// directed corner cases first and then biased random traffic, with bursty
// requests and a stalling receiver; the checker scores every result.
// ----------------------------------------------------------------------------

module tb_ordered_list_store_unit;

  localparam int unsigned              Capacity   = 16;
  localparam int                       RandomReqs = 200;
  localparam logic [ols_pkg::ReqW-1:0] ReqUnused  = 2'd3;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  logic [ols_pkg::ReqW-1:0]         req_type_i = '0;
  logic signed [ols_pkg::DataW-1:0] item_value_i = '0;
  logic [ols_pkg::PosW-1:0]         position_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic signed [ols_pkg::DataW-1:0] element_o;
  logic                             last_of_run_o;
  logic                             list_empty_o;
  logic                             insert_dropped_o;

  int fail_count;
  int pending;
  int burst_left = 1;

  always #4 clk_i = ~clk_i;

  ordered_list_store_unit #(.CAPACITY(Capacity)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .item_value_i    (item_value_i),
    .position_i      (position_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .element_o       (element_o),
    .last_of_run_o   (last_of_run_o),
    .list_empty_o    (list_empty_o),
    .insert_dropped_o(insert_dropped_o)
  );

  ols_list_checker #(.CAPACITY(Capacity)) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .req_type_i      (req_type_i),
    .item_value_i    (item_value_i),
    .position_i      (position_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .element_i       (element_o),
    .last_of_run_i   (last_of_run_o),
    .list_empty_i    (list_empty_o),
    .insert_dropped_i(insert_dropped_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Receiver: free-running, sporadic single stalls, or long stall runs.
  int stall_cnt = 0;
  int stall_mode = 0;
  int stall_run = 0;

  always @(posedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 2);
    if (stall_run > 0) begin
      stall_run   <= stall_run - 1;
      out_stall_i <= 1'b1;
    end else if (stall_mode == 1) begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
    end else if (stall_mode == 2 && $urandom_range(0, 7) == 0) begin
      stall_run   <= $urandom_range(1, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic logic signed [ols_pkg::DataW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       pick_value = 32'sh8000_0000;
      1:       pick_value = 32'sh7fff_ffff;
      2:       pick_value = $urandom_range(0, 16) - 8;
      default: pick_value = $urandom;
    endcase
  endfunction

  function automatic logic [ols_pkg::PosW-1:0] pick_position();
    if ($urandom_range(0, 7) == 0)
      pick_position = ols_pkg::PosW'($urandom_range(0, 255));
    else
      pick_position = ols_pkg::PosW'($urandom_range(0, Capacity));
  endfunction

  // Present one request and hold it until the transaction completes.
  // Stall is sampled at the falling edge, where it is settled for the next rise.
  task automatic push_request(
    input logic [ols_pkg::ReqW-1:0]         kind,
    input logic signed [ols_pkg::DataW-1:0] value,
    input logic [ols_pkg::PosW-1:0]         pos
  );
    logic taken;
    req_type_i   <= kind;
    item_value_i <= value;
    position_i   <= pos;
    in_valid_i   <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 6);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  initial begin
    int                       mood;
    int                       roll;
    int                       insert_pct;
    logic [ols_pkg::ReqW-1:0] kind;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: out-of-range delete and unused code, then grow and shrink a short list
    push_request(ols_pkg::ReqDelete, 32'sh0bad_cafe, 8'd0);
    push_request(ReqUnused, 32'sh1234_5678, 8'hff);
    push_request(ols_pkg::ReqPushFront, 32'sh8000_0000, 8'd0);
    push_request(ols_pkg::ReqAppend, 32'sh7fff_ffff, 8'hff);
    push_request(ols_pkg::ReqPushFront, 32'sd0, 8'd0);
    push_request(ols_pkg::ReqAppend, -32'sd1, 8'd0);
    push_request(ols_pkg::ReqDelete, 32'sd0, 8'hff);
    push_request(ols_pkg::ReqDelete, 32'sd0, 8'd4);   // position equal to count
    push_request(ols_pkg::ReqDelete, 32'sd0, 8'd1);
    push_request(ols_pkg::ReqDelete, 32'sd0, 8'd2);   // tail
    push_request(ols_pkg::ReqDelete, 32'sd0, 8'd0);   // head
    drain_results();

    // fill up, then hit the full-store cases
    for (int k = 1; k < Capacity; k++)
      push_request(k[0] ? ols_pkg::ReqAppend : ols_pkg::ReqPushFront, pick_value(),
                   pick_position());
    push_request(ols_pkg::ReqPushFront, 32'sh5555_5555, 8'd0);
    push_request(ols_pkg::ReqAppend, 32'shaaaa_aaaa, 8'd0);
    push_request(ReqUnused, pick_value(), pick_position());
    push_request(ols_pkg::ReqDelete, pick_value(), ols_pkg::PosW'(Capacity - 1));
    push_request(ols_pkg::ReqDelete, pick_value(), 8'd0);
    drain_results();

    // random traffic in phases that grow, shrink or churn the list
    mood = 0;
    for (int n = 0; n < RandomReqs; n++) begin
      if (n % 25 == 0) mood = $urandom_range(0, 2);
      insert_pct = (mood == 0) ? 80 : (mood == 1) ? 25 : 55;
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) kind = roll[0] ? ols_pkg::ReqAppend : ols_pkg::ReqPushFront;
      else if (roll < 97)    kind = ols_pkg::ReqDelete;
      else                   kind = ReqUnused;
      push_request(kind, pick_value(), pick_position());
      if ($urandom_range(0, 29) == 0) drain_results();
    end

    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (2 * Capacity + 8) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_ordered_list_store_unit: PASS");
    end else begin
      $display("tb_ordered_list_store_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb_ordered_list_store_unit: FAIL");
    $finish;
  end

endmodule
